### rtl/kwsc_pkg.sv
// Package for the keyword substitution cipher core.
// Holds item kinds, sequencer states, the letter decode function and shared structs.
// No dependencies.
package kwsc_pkg;

	localparam int unsigned LETTERS = 26;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned CNT_W   = 5;

	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_Z = 8'h5A;
	localparam logic [7:0] CHAR_LO_A = 8'h61;
	localparam logic [7:0] CHAR_LO_Z = 8'h7A;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LETTERS);

	typedef enum logic [1:0] {
		KIND_KEY    = 2'd0,
		KIND_FINISH = 2'd1,
		KIND_TEXT   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_FILL = 1'b1
	} state_t;

	// decoded letter of an input byte
	typedef struct packed {
		logic             hit;
		logic             lower;
		logic [IDX_W-1:0] idx;
	} letter_t;

	// request to the shared place unit
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} place_t;

	function automatic letter_t letter_decode(input logic [7:0] b);
		letter_t     r;
		logic [7:0]  d;
		r = '0;
		d = '0;
		if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
			d       = b - CHAR_UP_A;
			r.hit   = 1'b1;
			r.idx   = d[IDX_W-1:0];
		end else if (b >= CHAR_LO_A && b <= CHAR_LO_Z) begin
			d       = b - CHAR_LO_A;
			r.hit   = 1'b1;
			r.lower = 1'b1;
			r.idx   = d[IDX_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/kwsc_store.sv
// Cipher alphabet store: table, used-letter mask and fill count with the place unit.
// Depends on kwsc_pkg.
module kwsc_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kwsc_pkg::place_t            place,
	input  logic                        clear,
	input  logic [kwsc_pkg::IDX_W-1:0]  rd_idx,
	output logic [kwsc_pkg::IDX_W-1:0]  rd_data,
	output logic [kwsc_pkg::LETTERS-1:0] used_mask
);

	logic [kwsc_pkg::IDX_W-1:0]   table_q [kwsc_pkg::LETTERS];
	logic [kwsc_pkg::LETTERS-1:0] used_q;
	logic [kwsc_pkg::CNT_W-1:0]   fill_q;
	logic                         wr_en;

	assign wr_en = place.valid && (fill_q < kwsc_pkg::FULL_CNT);

	// table: identity on reset and clear, append at fill position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kwsc_pkg::LETTERS; i++) begin
				table_q[i] <= kwsc_pkg::IDX_W'(i);
			end
		end else if (clear) begin
			for (int i = 0; i < kwsc_pkg::LETTERS; i++) begin
				table_q[i] <= kwsc_pkg::IDX_W'(i);
			end
		end else if (wr_en) begin
			table_q[fill_q] <= place.idx;
		end
	end

	// used mask and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			fill_q <= '0;
		end else if (clear) begin
			used_q <= '0;
			fill_q <= '0;
		end else if (place.valid) begin
			used_q[place.idx] <= 1'b1;
			if (wr_en) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign rd_data   = table_q[rd_idx];
	assign used_mask = used_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= kwsc_pkg::FULL_CNT)
		else $error("fill count past alphabet size");

	a_fill_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(fill_q))
		else $error("fill count disagrees with used mask");

endmodule

### rtl/kwsc_ctrl.sv
// Sequencer for the cipher core: drives the place unit for keyword bytes and
// walks the 26 letters for a finish item. Depends on kwsc_pkg.
module kwsc_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         key_acc,
	input  logic                         finish_acc,
	input  kwsc_pkg::letter_t            key_letter,
	input  logic [kwsc_pkg::LETTERS-1:0] used_mask,
	output kwsc_pkg::place_t             place,
	output logic                         idle
);

	kwsc_pkg::state_t            state_q, state_d;
	logic [kwsc_pkg::IDX_W-1:0]  walk_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kwsc_pkg::ST_IDLE: begin
				if (finish_acc) state_d = kwsc_pkg::ST_FILL;
			end
			kwsc_pkg::ST_FILL: begin
				if (walk_q == kwsc_pkg::LAST_IDX) state_d = kwsc_pkg::ST_IDLE;
			end
			default: state_d = kwsc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// letter walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (state_q == kwsc_pkg::ST_FILL) begin
			walk_q <= (walk_q == kwsc_pkg::LAST_IDX) ? '0 : walk_q + 1'b1;
		end else begin
			walk_q <= '0;
		end
	end

	// outputs: place request for the shared unit
	always_comb begin
		place = '0;
		idle  = 1'b0;
		unique case (state_q)
			kwsc_pkg::ST_IDLE: begin
				idle        = 1'b1;
				place.idx   = key_letter.idx;
				place.valid = key_acc && key_letter.hit && !used_mask[key_letter.idx];
			end
			kwsc_pkg::ST_FILL: begin
				place.idx   = walk_q;
				place.valid = !used_mask[walk_q];
			end
			default: begin
				idle = 1'b0;
			end
		endcase
	end

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kwsc_pkg::ST_FILL |-> walk_q <= kwsc_pkg::LAST_IDX)
		else $error("walk counter out of range");

	a_place_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		place.valid |-> !used_mask[place.idx])
		else $error("placing a letter already used");

	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == kwsc_pkg::ST_FILL) |-> walk_q == '0)
		else $error("letter walk did not start at A");

endmodule

### rtl/keyword_substitution_cipher_core.sv
// Keyword substitution cipher core: top level with stream ports and output register.
// A text item's result is registered and appears in the cycle after acceptance; one item
// per cycle while the output is taken and no letter walk runs. A finish item walks all 26
// letters through the shared place unit and holds s_tready low while the walk runs.
// Reset (arst_n low, asynchronous) sets the table to identity, clears the used mask
// and fill count, and empties the output register. Depends on kwsc_pkg, kwsc_ctrl, kwsc_store.
module keyword_substitution_cipher_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic [1:0] s_tuser,   // [1:0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [7:0] out_byte
);

	logic                         in_acc;
	logic                         ctrl_idle;
	kwsc_pkg::kind_t              kind;
	kwsc_pkg::letter_t            letter;
	kwsc_pkg::place_t             place;
	logic [kwsc_pkg::LETTERS-1:0] used_mask;
	logic [kwsc_pkg::IDX_W-1:0]   cipher_idx;
	logic [7:0]                   enc_byte;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;

	assign kind     = kwsc_pkg::kind_t'(s_tuser);
	assign letter   = kwsc_pkg::letter_decode(s_tdata);
	assign s_tready = ctrl_idle && (!out_valid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;

	kwsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_acc    (in_acc && kind == kwsc_pkg::KIND_KEY),
		.finish_acc (in_acc && kind == kwsc_pkg::KIND_FINISH),
		.key_letter (letter),
		.used_mask  (used_mask),
		.place      (place),
		.idle       (ctrl_idle)
	);

	kwsc_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.place     (place),
		.clear     (in_acc && kind == kwsc_pkg::KIND_CLEAR),
		.rd_idx    (letter.idx),
		.rd_data   (cipher_idx),
		.used_mask (used_mask)
	);

	// encrypt: keep case, non-letters pass through
	always_comb begin
		if (!letter.hit) begin
			enc_byte = s_tdata;
		end else if (letter.lower) begin
			enc_byte = kwsc_pkg::CHAR_LO_A + 8'(cipher_idx);
		end else begin
			enc_byte = kwsc_pkg::CHAR_UP_A + 8'(cipher_idx);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && kind == kwsc_pkg::KIND_TEXT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && kind == kwsc_pkg::KIND_TEXT) begin
			out_byte_q <= enc_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> ctrl_idle)
		else $error("input ready during letter walk");

	a_text_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind == kwsc_pkg::KIND_TEXT |=> out_valid_q)
		else $error("text item gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |=> !out_valid_q || $past(in_acc && kind == kwsc_pkg::KIND_TEXT))
		else $error("result without a text item");

endmodule

### tb/keyword_substitution_cipher_core_test.sv
// Testbench for keyword_substitution_cipher_core: directed, back-pressure and random tests.
// A built-in predictor of key building and encryption checks every output byte in order.
// Depends on kwsc_pkg and keyword_substitution_cipher_core.
module keyword_substitution_cipher_core_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 90;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_SELDOM,
		RX_PERIODIC
	} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] in_byte
	logic [1:0] s_tuser;   // [1:0] kind
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;   // [7:0] out_byte

	// predictor state: plain letter index -> cipher letter index
	logic [kwsc_pkg::IDX_W-1:0] cipher_map [kwsc_pkg::LETTERS];
	logic [kwsc_pkg::LETTERS-1:0] placed_mask;
	logic [kwsc_pkg::CNT_W-1:0] placed_count;
	logic [7:0] expected_bytes [$];

	int items_sent;
	int bytes_checked;
	int keys_finished;
	int errors;
	int cycle_count;
	bit gap_on;
	int burst_left;

	// receiver pattern state
	int hold_token;
	int hold_seen;
	int hold_left;
	int phase_left;
	rx_mode_t rx_mode;
	int rx_tick;

	keyword_substitution_cipher_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------

	// letter index 0..25 for either case, -1 for anything else
	function automatic int letter_of(input logic [7:0] b);
		if (b >= kwsc_pkg::CHAR_UP_A && b <= kwsc_pkg::CHAR_UP_Z)
			return int'(b) - int'(kwsc_pkg::CHAR_UP_A);
		if (b >= kwsc_pkg::CHAR_LO_A && b <= kwsc_pkg::CHAR_LO_Z)
			return int'(b) - int'(kwsc_pkg::CHAR_LO_A);
		return -1;
	endfunction

	task automatic restart_cipher();
		for (int i = 0; i < kwsc_pkg::LETTERS; i++)
			cipher_map[i] = kwsc_pkg::IDX_W'(i);
		placed_mask = '0;
		placed_count = '0;
	endtask

	task automatic place_letter(input int li);
		if (placed_count < kwsc_pkg::FULL_CNT) begin
			cipher_map[placed_count] = kwsc_pkg::IDX_W'(li);
			placed_count = placed_count + 1'b1;
		end
		placed_mask[li] = 1'b1;
	endtask

	task automatic advance_cipher(input kwsc_pkg::kind_t k, input logic [7:0] b);
		int li;
		logic [7:0] base;
		li = letter_of(b);
		case (k)
			kwsc_pkg::KIND_KEY: begin
				if (li >= 0 && !placed_mask[li])
					place_letter(li);
			end
			kwsc_pkg::KIND_FINISH: begin
				keys_finished++;
				for (int i = 0; i < kwsc_pkg::LETTERS; i++)
					if (!placed_mask[i])
						place_letter(i);
			end
			kwsc_pkg::KIND_TEXT: begin
				if (li < 0) begin
					expected_bytes.push_back(b);
				end else begin
					base = (b >= kwsc_pkg::CHAR_LO_A) ? kwsc_pkg::CHAR_LO_A
						: kwsc_pkg::CHAR_UP_A;
					expected_bytes.push_back(base + 8'(cipher_map[li]));
				end
			end
			default: restart_cipher();
		endcase
	endtask

	// track accepted items first, then check the output side
	always @(posedge clk) begin : scoreboard
		logic [7:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				advance_cipher(kwsc_pkg::kind_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected output %02h, nothing expected", $time, m_tdata);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (m_tdata !== want) begin
						$display("%0t: ciphertext mismatch: expected %02h actual %02h",
							$time, want, m_tdata);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d bytes still expected", $time, expected_bytes.size());
			$display("keyword_substitution_cipher_core regression: fail");
			$finish;
		end
	end

	// ---------------- receiver ----------------

	// changing stall patterns, plus a long hold-off on request
	always @(negedge clk) begin
		rx_tick++;
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else begin
			if (phase_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				phase_left = $urandom_range(16, 200);
			end
			phase_left--;
			case (rx_mode)
				RX_ALWAYS:   m_tready = 1'b1;
				RX_MOSTLY:   m_tready = ($urandom_range(0, 3) != 0);
				RX_SELDOM:   m_tready = ($urandom_range(0, 3) == 0);
				default:     m_tready = (rx_tick % 3 != 0);
			endcase
		end
	end

	// ---------------- sender ----------------

	function automatic logic [7:0] random_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? kwsc_pkg::CHAR_LO_A : kwsc_pkg::CHAR_UP_A;
		return base + 8'($urandom_range(0, kwsc_pkg::LETTERS - 1));
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input kwsc_pkg::kind_t k, input logic [7:0] b);
		if (gap_on && burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid = 1'b1;
		s_tuser = k;
		s_tdata = b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_for_results();
		while (expected_bytes.size() != 0)
			@(negedge clk);
	endtask

	task automatic request_hold();
		@(posedge clk);
		hold_token++;
		@(negedge clk);
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		gap_on = 1'b0;
		// identity table after reset, letter bounds and non-letters
		send_item(kwsc_pkg::KIND_TEXT, kwsc_pkg::CHAR_UP_A);
		send_item(kwsc_pkg::KIND_TEXT, kwsc_pkg::CHAR_LO_Z);
		send_item(kwsc_pkg::KIND_TEXT, 8'h40);
		send_item(kwsc_pkg::KIND_TEXT, 8'h5B);
		send_item(kwsc_pkg::KIND_TEXT, 8'h60);
		send_item(kwsc_pkg::KIND_TEXT, 8'h7B);
		send_item(kwsc_pkg::KIND_TEXT, 8'hFF);
		send_item(kwsc_pkg::KIND_TEXT, 8'h80);
		// keyword with a repeat, a digit and a high byte
		send_item(kwsc_pkg::KIND_KEY, kwsc_pkg::CHAR_UP_Z);
		send_item(kwsc_pkg::KIND_KEY, "e");
		send_item(kwsc_pkg::KIND_KEY, "E");
		send_item(kwsc_pkg::KIND_KEY, "1");
		send_item(kwsc_pkg::KIND_KEY, 8'hC1);
		// lookup on a half-built table
		send_item(kwsc_pkg::KIND_TEXT, "a");
		send_item(kwsc_pkg::KIND_TEXT, "D");
		// finish twice, keyword byte after finish is a no-op
		send_item(kwsc_pkg::KIND_FINISH, 8'h00);
		send_item(kwsc_pkg::KIND_FINISH, 8'hFF);
		send_item(kwsc_pkg::KIND_KEY, "Q");
		send_item(kwsc_pkg::KIND_TEXT, "a");
		send_item(kwsc_pkg::KIND_TEXT, kwsc_pkg::CHAR_UP_Z);
		send_item(kwsc_pkg::KIND_TEXT, "m");
		// clear back to identity
		send_item(kwsc_pkg::KIND_CLEAR, 8'hA5);
		send_item(kwsc_pkg::KIND_TEXT, "b");
		send_item(kwsc_pkg::KIND_TEXT, "Y");
		wait_for_results();
	endtask

	// output side held off while input keeps coming, then a full drain
	task automatic test_backpressure();
		wait_for_results();
		gap_on = 1'b0;
		request_hold();
		repeat (40) send_item(kwsc_pkg::KIND_TEXT, random_letter());
		wait_for_results();
	endtask

	task automatic test_random_sessions(input int target);
		int key_len;
		int text_len;
		while (items_sent < target) begin
			gap_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				// noise: any kind, any byte
				repeat ($urandom_range(5, 20))
					send_item(kwsc_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom));
			end else begin
				if ($urandom_range(0, 4) != 0)
					send_item(kwsc_pkg::KIND_CLEAR, 8'($urandom));
				key_len = $urandom_range(0, 30);
				repeat (key_len)
					send_item(kwsc_pkg::KIND_KEY,
						($urandom_range(0, 6) != 0) ? random_letter() : 8'($urandom));
				if ($urandom_range(0, 9) != 0)
					send_item(kwsc_pkg::KIND_FINISH, 8'($urandom));
				if ($urandom_range(0, 7) == 0) begin
					send_item(kwsc_pkg::KIND_KEY, random_letter());
					send_item(kwsc_pkg::KIND_FINISH, 8'($urandom));
				end
				text_len = $urandom_range(5, 50);
				repeat (text_len)
					send_item(kwsc_pkg::KIND_TEXT,
						($urandom_range(0, 3) != 0) ? random_letter() : 8'($urandom));
			end
			if ($urandom_range(0, 7) == 0)
				wait_for_results();
		end
	endtask

	// ---------------- main ----------------

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = kwsc_pkg::KIND_KEY;
		restart_cipher();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_random_sessions(900);
		test_backpressure();
		test_random_sessions(1850);

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d items: %0d cipher bytes checked across %0d finished keys,",
			items_sent, bytes_checked, keys_finished);
		$display("with directed edge cases, long output hold-offs and random stalls");
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("keyword_substitution_cipher_core regression: pass");
		end else begin
			$display("%0d errors, %0d bytes never seen", errors, expected_bytes.size());
			$display("keyword_substitution_cipher_core regression: fail");
		end
		$finish;
	end

endmodule
